>>> src/irsel_pkg.sv
// shared types and constants for the ir remote input selector
package irsel_pkg;

	localparam int unsigned FRAME_W = 12;
	localparam logic [3:0] TOP_BIT = 4'd11;
	localparam logic [2:0] HDR_OK = 3'b101;
	localparam logic [5:0] CODE_LOW_VAL = 6'b001000;
	localparam logic [5:0] CODE_MID_VAL = 6'b010000;
	localparam logic [5:0] CODE_HIGH_VAL = 6'b100000;

	localparam int unsigned ERR_S1 = 0;
	localparam int unsigned ERR_H = 1;

	localparam logic CFG_THRESHOLD = 1'b0;
	localparam logic CFG_TOP_LEVEL = 1'b1;

	typedef enum logic [1:0] {
		REQ_PULSE = 2'd0,
		REQ_LEVEL = 2'd1,
		REQ_ENCODER = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		DRV_STOP = 2'd0,
		DRV_CW = 2'd1,
		DRV_CCW = 2'd2
	} drive_t;

	typedef enum logic [1:0] {
		ST_NONE = 2'd0,
		ST_OK = 2'd1,
		ST_DIFFER = 2'd2,
		ST_BAD_HDR = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CODE_LOW = 2'd0,
		CODE_MID = 2'd1,
		CODE_HIGH = 2'd2,
		CODE_OTHER = 2'd3
	} code_t;

	typedef struct packed {
		logic done;
		status_t status;
		logic s1_en;
		logic h_en;
		code_t code;
		logic [1:0] err;
	} frame_cmd_t;

	typedef struct packed {
		logic step;
		logic cw;
	} enc_step_t;

endpackage

>>> src/ir_remote_input_selector_core.sv
// top level: input register, channel and volume control, result register
//
//  channel | handshake           | payload
//  in      | in_valid / in_stall | req_type pulse_ticks level phase_a phase_b
//  out     | out_valid/out_stall | channel motor_drive frame_status command_error level_target
//  cfg     | cfg_we              | cfg_index cfg_data
//
// one item per cycle unless stalled; items pass the input register, then the result register
// all state updates in one pass between the input register and the result register
// reset clears valid flags and levels; channel resets to 0001, threshold to 71, top level to 4
// out_stall holds the result and backs up into in_stall after one buffered item
module ir_remote_input_selector_core (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] req_type,
	input  logic [7:0] pulse_ticks,
	input  logic [3:0] level,
	input  logic phase_a,
	input  logic phase_b,
	output logic out_valid,
	input  logic out_stall,
	output logic [3:0] channel,
	output logic [1:0] motor_drive,
	output logic [1:0] frame_status,
	output logic [1:0] command_error,
	output logic [3:0] level_target,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [7:0] cfg_data
);

	logic [7:0] thr_q;
	logic [3:0] top_q;

	logic valid_s1;
	irsel_pkg::req_t req_s1;
	logic [7:0] ticks_s1;
	logic [3:0] level_s1;
	logic a_s1;
	logic b_s1;

	logic [3:0] channel_q;
	logic [3:0] cur_q;
	logic [3:0] tgt_q;
	logic moving_q;
	irsel_pkg::drive_t drv_q;

	logic out_valid_s2;
	logic [3:0] channel_s2;
	logic [1:0] drive_s2;
	logic [1:0] status_s2;
	logic [1:0] err_s2;
	logic [3:0] target_s2;

	logic load_ok;
	logic adv;
	logic in_xfer;

	irsel_pkg::frame_cmd_t fcmd;
	irsel_pkg::enc_step_t estep;

	logic [3:0] chan_n;
	logic [3:0] cur_n;
	logic [3:0] tgt_n;
	logic mov_n;
	irsel_pkg::drive_t drv_n;
	irsel_pkg::status_t status_n;
	logic [1:0] err_n;

	assign load_ok = !out_valid_s2 || !out_stall;
	assign adv = valid_s1 && load_ok;
	assign in_stall = valid_s1 && !load_ok;
	assign in_xfer = in_valid && !in_stall;

	irsel_frame_rx u_frame_rx (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv && (req_s1 == irsel_pkg::REQ_PULSE)),
		.pulse_ticks(ticks_s1),
		.threshold(thr_q),
		.cmd(fcmd)
	);

	irsel_encoder u_encoder (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv && (req_s1 == irsel_pkg::REQ_ENCODER)),
		.phase_a(a_s1),
		.phase_b(b_s1),
		.step(estep)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 8'd71;
			top_q <= 4'd4;
		end else if (cfg_we) begin
			case (cfg_index)
				irsel_pkg::CFG_THRESHOLD: thr_q <= cfg_data;
				irsel_pkg::CFG_TOP_LEVEL: top_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_s1 <= irsel_pkg::req_t'(req_type);
			ticks_s1 <= pulse_ticks;
			level_s1 <= level;
			a_s1 <= phase_a;
			b_s1 <= phase_b;
		end
	end

	always_comb begin
		chan_n = channel_q;
		cur_n = cur_q;
		tgt_n = tgt_q;
		mov_n = moving_q;
		drv_n = drv_q;
		status_n = irsel_pkg::ST_NONE;
		err_n = '0;
		case (req_s1)
			irsel_pkg::REQ_PULSE: begin
				if (fcmd.done) begin
					status_n = fcmd.status;
					err_n = fcmd.err;
					if (fcmd.s1_en) begin
						case (fcmd.code)
							irsel_pkg::CODE_LOW: chan_n = 4'b1000;
							irsel_pkg::CODE_MID: chan_n = 4'b0100;
							irsel_pkg::CODE_HIGH: chan_n = 4'b0001;
							default: ;
						endcase
					end
					// h group channel select wins over s1 for the low code when both are set
					if (fcmd.h_en) begin
						case (fcmd.code)
							irsel_pkg::CODE_LOW: chan_n = 4'b0010;
							irsel_pkg::CODE_MID: begin
								if (cur_q != 4'd0) begin
									tgt_n = (tgt_q != 4'd0) ? (tgt_q - 4'd1) : tgt_q;
									drv_n = irsel_pkg::DRV_CCW;
									mov_n = 1'b1;
								end
							end
							irsel_pkg::CODE_HIGH: begin
								if (cur_q < top_q) begin
									tgt_n = (tgt_q != 4'hF) ? (tgt_q + 4'd1) : tgt_q;
									drv_n = irsel_pkg::DRV_CW;
									mov_n = 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
			end
			irsel_pkg::REQ_LEVEL: begin
				if (level_s1 != cur_q) begin
					cur_n = level_s1;
					if (!moving_q) begin
						tgt_n = level_s1;
					end
				end
			end
			irsel_pkg::REQ_ENCODER: begin
				if (estep.step) begin
					if (estep.cw) begin
						chan_n = (channel_q == 4'b1000) ? 4'b0001 : {channel_q[2:0], 1'b0};
					end else begin
						chan_n = (channel_q == 4'b0001) ? 4'b1000 : {1'b0, channel_q[3:1]};
					end
				end
			end
			default: ;
		endcase
		// motor stops once the level reaches the target
		if (cur_n == tgt_n) begin
			drv_n = irsel_pkg::DRV_STOP;
			mov_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_q <= 4'b0001;
			cur_q <= '0;
			tgt_q <= '0;
			moving_q <= 1'b0;
			drv_q <= irsel_pkg::DRV_STOP;
		end else if (adv) begin
			channel_q <= chan_n;
			cur_q <= cur_n;
			tgt_q <= tgt_n;
			moving_q <= mov_n;
			drv_q <= drv_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (adv) begin
			out_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			channel_s2 <= chan_n;
			drive_s2 <= drv_n;
			status_s2 <= status_n;
			err_s2 <= err_n;
			target_s2 <= tgt_n;
		end
	end

	assign out_valid = out_valid_s2;
	assign channel = channel_s2;
	assign motor_drive = drive_s2;
	assign frame_status = status_s2;
	assign command_error = err_s2;
	assign level_target = target_s2;

	assert property (@(posedge clk) disable iff (!arst_n) $onehot(channel_q))
		else $error("channel register lost its one-hot code");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cur_q == tgt_q) |-> (drv_q == irsel_pkg::DRV_STOP && !moving_q))
		else $error("motor still driven at target level");

	assert property (@(posedge clk) disable iff (!arst_n) in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && command_error != 2'd0) |-> (frame_status == irsel_pkg::ST_OK))
		else $error("command error reported without an accepted frame pair");

	assert property (@(posedge clk) disable iff (!arst_n) adv |=> out_valid)
		else $error("transfer into result register lost");

endmodule

>>> src/irsel_frame_rx.sv
// ir bit shifter, frame pair store and pair check
module irsel_frame_rx (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic [7:0] pulse_ticks,
	input  logic [7:0] threshold,
	output irsel_pkg::frame_cmd_t cmd
);

	logic [3:0] bit_pos_q;
	logic [1:0] held_q;
	logic [irsel_pkg::FRAME_W-1:0] frame0_q;
	logic [irsel_pkg::FRAME_W-1:0] frame1_q;

	logic set_bit;
	logic wrap;
	logic [irsel_pkg::FRAME_W-1:0] mask;
	logic [irsel_pkg::FRAME_W-1:0] frame0_n;
	logic [irsel_pkg::FRAME_W-1:0] frame1_n;
	logic [1:0] held_n;
	logic [3:0] bit_pos_n;
	logic [5:0] data;

	always_comb begin
		set_bit = (pulse_ticks > threshold) && (bit_pos_q <= irsel_pkg::TOP_BIT);
		wrap = (bit_pos_q == 4'd0) || (bit_pos_q > irsel_pkg::TOP_BIT);
		mask = set_bit ? (irsel_pkg::FRAME_W'(1) << bit_pos_q) : '0;
		frame0_n = held_q[0] ? frame0_q : (frame0_q | mask);
		frame1_n = held_q[0] ? (frame1_q | mask) : frame1_q;
		held_n = wrap ? (held_q + 2'd1) : held_q;
		bit_pos_n = wrap ? irsel_pkg::TOP_BIT : (bit_pos_q - 4'd1);
		data = frame0_n[5:0];

		cmd = '0;
		cmd.status = irsel_pkg::ST_NONE;
		if (data == irsel_pkg::CODE_LOW_VAL) begin
			cmd.code = irsel_pkg::CODE_LOW;
		end else if (data == irsel_pkg::CODE_MID_VAL) begin
			cmd.code = irsel_pkg::CODE_MID;
		end else if (data == irsel_pkg::CODE_HIGH_VAL) begin
			cmd.code = irsel_pkg::CODE_HIGH;
		end else begin
			cmd.code = irsel_pkg::CODE_OTHER;
		end
		cmd.done = held_n[1];
		if (held_n[1]) begin
			if (frame0_n != frame1_n) begin
				cmd.status = irsel_pkg::ST_DIFFER;
			end else if (frame0_n[11:9] != irsel_pkg::HDR_OK) begin
				cmd.status = irsel_pkg::ST_BAD_HDR;
			end else begin
				cmd.status = irsel_pkg::ST_OK;
				cmd.s1_en = frame0_n[7];
				cmd.h_en = frame0_n[8];
				cmd.err[irsel_pkg::ERR_S1] = frame0_n[7] && (cmd.code == irsel_pkg::CODE_OTHER);
				cmd.err[irsel_pkg::ERR_H] = frame0_n[8] && (cmd.code == irsel_pkg::CODE_OTHER);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_pos_q <= irsel_pkg::TOP_BIT;
			held_q <= '0;
			frame0_q <= '0;
			frame1_q <= '0;
		end else if (en) begin
			bit_pos_q <= bit_pos_n;
			if (held_n[1]) begin
				// pair checked, then discarded
				held_q <= '0;
				frame0_q <= '0;
				frame1_q <= '0;
			end else begin
				held_q <= held_n;
				frame0_q <= frame0_n;
				frame1_q <= frame1_n;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) bit_pos_q <= irsel_pkg::TOP_BIT && !held_q[1])
		else $error("frame bit position or pair count out of range");

endmodule

>>> src/irsel_encoder.sv
// quadrature encoder sample tracking and channel step detection
module irsel_encoder (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic phase_a,
	input  logic phase_b,
	output irsel_pkg::enc_step_t step
);

	logic last_a_q;
	logic last_b_q;
	logic last_dir_q;
	logic [1:0] turn_q;

	logic moved;
	logic dir;

	always_comb begin
		moved = (phase_a != last_a_q) && (phase_b != last_b_q);
		dir = phase_a ^ phase_b;
		step.step = moved && ((dir != last_dir_q) || (turn_q >= 2'd2));
		step.cw = dir;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_a_q <= 1'b0;
			last_b_q <= 1'b0;
			last_dir_q <= 1'b0;
			turn_q <= '0;
		end else if (en && (phase_a != last_a_q)) begin
			last_a_q <= phase_a;
			if (phase_b != last_b_q) begin
				last_b_q <= phase_b;
				last_dir_q <= dir;
				turn_q <= step.step ? 2'd1 : (turn_q + 2'd1);
			end
		end
	end

endmodule
